>>> rtl/core/smd_pkg.sv
// smd_pkg: shared constants, command codes and interface structs for the
// sorted merge with duplicate removal. No dependencies.
package smd_pkg;

  localparam int ARRAY_DEPTH = 32;
  localparam int KEY_W       = 64;
  localparam int POS_W       = 64;
  localparam int IDX_W       = $clog2(ARRAY_DEPTH + 1);
  localparam int ADDR_W      = (ARRAY_DEPTH > 1) ? $clog2(ARRAY_DEPTH) : 1;

  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(ARRAY_DEPTH);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FILE  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } record_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    record_t           wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  typedef struct packed {
    logic    valid;
    logic    last;
    record_t rec;
  } push_t;

endpackage

>>> rtl/core/smd_store.sv
// smd_store: record store, one write port and one read port with
// registered read data. Depends on smd_pkg.
module smd_store (
  input  logic                clk,
  input  smd_pkg::store_req_t req,
  output smd_pkg::record_t    rd_data
);

  smd_pkg::record_t mem [smd_pkg::ARRAY_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> rtl/core/smd_cmp.sv
// smd_cmp: shared 64-bit unsigned magnitude compare unit.
// Depends on smd_pkg.
module smd_cmp (
  input  logic [smd_pkg::KEY_W-1:0] a,
  input  logic [smd_pkg::KEY_W-1:0] b,
  output logic                      lt,
  output logic                      eq
);

  assign lt = (a < b);
  assign eq = (a == b);

endmodule

>>> rtl/core/smd_seq.sv
// smd_seq: sequencer that walks the store run by run, drives the shared
// compare unit and holds one pending result. Depends on smd_pkg.
module smd_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [smd_pkg::KEY_W-1:0]     rec_key,
  input  logic [smd_pkg::POS_W-1:0]     rec_position,
  output smd_pkg::store_req_t           store_req,
  input  smd_pkg::record_t              store_q,
  output logic [smd_pkg::KEY_W-1:0]     cmp_a,
  output logic [smd_pkg::KEY_W-1:0]     cmp_b,
  input  logic                          cmp_lt,
  input  logic                          cmp_eq,
  input  logic                          out_free,
  output smd_pkg::push_t                push
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_HEAD, S_RUNRD, S_RUNCMP, S_RUNMIN, S_ENDRUN, S_FIN, S_DONE
  } state_t;

  state_t                        state;
  logic [1:0]                    cmd_q;
  smd_pkg::record_t              file_rec;
  logic [smd_pkg::IDX_W-1:0]     fill_count;
  logic [smd_pkg::IDX_W-1:0]     read_index;
  logic [smd_pkg::KEY_W-1:0]     last_file_key;
  logic                          file_key_seen;
  smd_pkg::record_t              run_rec;
  logic                          run_emit;
  logic                          run_final;
  smd_pkg::record_t              pend;
  logic                          pend_valid;

  logic in_fire;
  logic more;
  logic slot_ok;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign more     = (read_index < fill_count);
  assign slot_ok  = !pend_valid || out_free;

  // store port
  always_comb begin
    store_req.wr_en       = in_fire && (command == smd_pkg::CMD_LOAD)
                            && (fill_count < smd_pkg::DEPTH_IDX);
    store_req.wr_addr     = fill_count[smd_pkg::ADDR_W-1:0];
    store_req.wr_data.key = rec_key;
    store_req.wr_data.pos = rec_position;
    store_req.rd_en       = ((state == S_RD) || (state == S_RUNRD)) && more;
    store_req.rd_addr     = read_index[smd_pkg::ADDR_W-1:0];
  end

  // compare operand select
  always_comb begin
    cmp_a = store_q.key;
    cmp_b = run_rec.key;
    case (state)
      S_HEAD:   cmp_b = (cmd_q == smd_pkg::CMD_FILE) ? file_rec.key : last_file_key;
      S_RUNCMP: cmp_b = run_rec.key;
      S_RUNMIN: begin
        cmp_a = store_q.pos;
        cmp_b = run_rec.pos;
      end
      default:  cmp_b = run_rec.key;
    endcase
  end

  // pending result moves to the output register on a newer result or item end
  always_comb begin
    push.valid = out_free && pend_valid &&
                 (((state == S_ENDRUN) && run_emit) ||
                  ((state == S_FIN) && (cmd_q == smd_pkg::CMD_FILE)) ||
                  (state == S_DONE));
    push.last  = (state == S_DONE);
    push.rec   = pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_count    <= '0;
      read_index    <= '0;
      last_file_key <= '0;
      file_key_seen <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_q        <= command;
            file_rec.key <= rec_key;
            file_rec.pos <= rec_position;
            if (command == smd_pkg::CMD_LOAD) begin
              if (fill_count < smd_pkg::DEPTH_IDX) begin
                fill_count <= fill_count + 1'b1;
              end
            end else if ((command == smd_pkg::CMD_FILE) ||
                         (command == smd_pkg::CMD_FLUSH)) begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= more ? S_HEAD : S_FIN;
        end
        S_HEAD: begin
          run_rec <= store_q;
          if (cmd_q == smd_pkg::CMD_FILE) begin
            if (cmp_lt || cmp_eq) begin
              run_emit   <= cmp_lt;
              run_final  <= cmp_eq;
              read_index <= read_index + 1'b1;
              state      <= S_RUNRD;
            end else begin
              state <= S_FIN;
            end
          end else begin
            run_emit   <= !(file_key_seen && cmp_eq);
            run_final  <= 1'b0;
            read_index <= read_index + 1'b1;
            state      <= S_RUNRD;
          end
        end
        S_RUNRD: begin
          state <= more ? S_RUNCMP : S_ENDRUN;
        end
        S_RUNCMP: begin
          state <= cmp_eq ? S_RUNMIN : S_ENDRUN;
        end
        S_RUNMIN: begin
          if (cmp_lt) begin
            run_rec.pos <= store_q.pos;
          end
          read_index <= read_index + 1'b1;
          state      <= S_RUNRD;
        end
        S_ENDRUN: begin
          if (!run_emit) begin
            state <= run_final ? S_FIN : S_RD;
          end else if (slot_ok) begin
            pend       <= run_rec;
            pend_valid <= 1'b1;
            state      <= S_RD;
          end
        end
        S_FIN: begin
          if (cmd_q != smd_pkg::CMD_FILE) begin
            state <= S_DONE;
          end else if (slot_ok) begin
            pend       <= file_rec;
            pend_valid <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (slot_ok) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
            if (cmd_q == smd_pkg::CMD_FILE) begin
              last_file_key <= file_rec.key;
              file_key_seen <= 1'b1;
            end else begin
              fill_count    <= '0;
              read_index    <= '0;
              last_file_key <= '0;
              file_key_seen <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/sorted_merge_dedup.sv
// sorted_merge_dedup: top level; output register, store, compare unit and
// sequencer. Depends on smd_pkg, smd_store, smd_cmp and smd_seq.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_ready, command, rec_key,     | to block
//           | rec_position                              |
//   out     | out_valid, out_ready, out_key,            | from block
//           | out_position, last_of_run                 |
//
// A load transfer leaves the block ready, so loads can follow back to back.
// A file record or flush walks the store through one registered read port
// and one shared 64-bit compare unit, with in_ready low throughout: setup
// and completion steps, then for each stored run walked a read, a head
// compare and an end step, and a read, compare and position step for each
// further record in a run.
// Synchronous active-high reset clears the fill count, read index, last
// file key, file-seen flag and pending result; the store is not cleared.
// A stalled output holds the sequencer only when a new result or item end
// must move the pending one out; the output register parts the two sides.
module sorted_merge_dedup (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                command,
  input  logic [smd_pkg::KEY_W-1:0] rec_key,
  input  logic [smd_pkg::POS_W-1:0] rec_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [smd_pkg::KEY_W-1:0] out_key,
  output logic [smd_pkg::POS_W-1:0] out_position,
  output logic                      last_of_run
);

  smd_pkg::store_req_t           store_req;
  smd_pkg::record_t              store_q;
  logic [smd_pkg::KEY_W-1:0]     cmp_a;
  logic [smd_pkg::KEY_W-1:0]     cmp_b;
  logic                          cmp_lt;
  logic                          cmp_eq;
  logic                          out_free;
  smd_pkg::push_t                push;

  // the output register can take a result when empty or draining
  assign out_free = !out_valid || out_ready;

  smd_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (store_q)
  );

  smd_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .lt (cmp_lt),
    .eq (cmp_eq)
  );

  smd_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .rec_key      (rec_key),
    .rec_position (rec_position),
    .store_req    (store_req),
    .store_q      (store_q),
    .cmp_a        (cmp_a),
    .cmp_b        (cmp_b),
    .cmp_lt       (cmp_lt),
    .cmp_eq       (cmp_eq),
    .out_free     (out_free),
    .push         (push)
  );

  // output register: load on a push, drop valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_key      <= push.rec.key;
      out_position <= push.rec.pos;
      last_of_run  <= push.last;
    end
  end

  // a push must never overwrite a result that has not been transferred
  a_push_room : assert property (@(posedge clk) disable iff (rst)
    push.valid |-> (!out_valid || out_ready))
    else $error("result pushed into a full output register");

  // a load leaves the block ready in the next cycle
  a_load_quick : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (command == smd_pkg::CMD_LOAD)) |=> in_ready)
    else $error("block not ready after a load");

  // a file record always starts a merge walk
  a_file_busy : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (command == smd_pkg::CMD_FILE)) |=> !in_ready)
    else $error("block ready straight after a file record");

  // the final result of an item keeps its last mark in the output register
  a_last_push : assert property (@(posedge clk) disable iff (rst)
    (push.valid && push.last) |=> (out_valid && last_of_run))
    else $error("final result lost its last mark");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for sorted_merge_dedup. A queued driver, a checking
// monitor and a behavioural merge predictor, clocked at the rising edge. Depends on smd_pkg.
module tb_top;

  // Command code 3 has no name in the package; the block must ignore it.
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 500;
  localparam logic [smd_pkg::KEY_W-1:0] KEY_MAX = '1;
  localparam logic [smd_pkg::POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [1:0]                cmd;
    logic [smd_pkg::KEY_W-1:0] key;
    logic [smd_pkg::POS_W-1:0] pos;
  } merge_req_t;

  typedef struct packed {
    logic [smd_pkg::KEY_W-1:0] key;
    logic [smd_pkg::POS_W-1:0] pos;
    logic                      last;
  } merged_rec_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                command = smd_pkg::CMD_LOAD;
  logic [smd_pkg::KEY_W-1:0] rec_key = '0;
  logic [smd_pkg::POS_W-1:0] rec_position = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [smd_pkg::KEY_W-1:0] out_key;
  logic [smd_pkg::POS_W-1:0] out_position;
  logic                      last_of_run;

  // Shadow of the block's store and merge pointers, updated on every input transfer.
  logic [smd_pkg::KEY_W-1:0] shadow_key [smd_pkg::ARRAY_DEPTH];
  logic [smd_pkg::POS_W-1:0] shadow_pos [smd_pkg::ARRAY_DEPTH];
  int                        shadow_fill = 0;
  int                        shadow_rd = 0;
  logic [smd_pkg::KEY_W-1:0] shadow_last_file = '0;
  bit                        shadow_file_seen = 1'b0;

  merge_req_t  req_q[$];     // items still to be driven
  merged_rec_t merged_q[$];  // merged records still owed by the block
  merge_req_t  next_req;
  merged_rec_t seen, want;
  int          mismatches = 0;
  int          counted_items = 0;
  int          cycles = 0;
  int          send_wait = 0, send_left = 0;
  int          recv_wait = 0, recv_left = 0;
  bit          send_quiet = 1'b0, recv_quiet = 1'b0;

  sorted_merge_dedup dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .rec_key      (rec_key),
    .rec_position (rec_position),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_key      (out_key),
    .out_position (out_position),
    .last_of_run  (last_of_run)
  );

  always #5 clk = ~clk;

  // Idle gap for one transfer. Each side alternates between quiet stretches
  // (no gaps at all) and busy stretches with a random gap for each transfer.
  function automatic int draw_gap(inout int left, inout bit quiet);
    if (left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      left = $urandom_range(8, 48);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // Consume the run of equal keys at the read pointer; give its smallest
  // position, the earliest one on ties.
  function automatic logic [smd_pkg::POS_W-1:0] consume_run();
    logic [smd_pkg::KEY_W-1:0] run_key;
    logic [smd_pkg::POS_W-1:0] best;
    run_key = shadow_key[shadow_rd];
    best = shadow_pos[shadow_rd];
    shadow_rd++;
    while (shadow_rd < shadow_fill && shadow_key[shadow_rd] == run_key) begin
      if (shadow_pos[shadow_rd] < best) best = shadow_pos[shadow_rd];
      shadow_rd++;
    end
    return best;
  endfunction

  // Work out the merged records one input transfer causes and queue them.
  function automatic void predict_merge(merge_req_t req);
    merged_rec_t batch[$];
    logic [smd_pkg::KEY_W-1:0] run_key;
    logic [smd_pkg::POS_W-1:0] run_pos;
    case (req.cmd)
      smd_pkg::CMD_LOAD: begin
        // Drop loads once the store is full.
        if (shadow_fill < smd_pkg::ARRAY_DEPTH) begin
          shadow_key[shadow_fill] = req.key;
          shadow_pos[shadow_fill] = req.pos;
          shadow_fill++;
        end
      end
      smd_pkg::CMD_FILE: begin
        // Release every stored run below the file key, then the file record
        // itself; a stored run with the same key gives way to it.
        while (shadow_rd < shadow_fill && shadow_key[shadow_rd] < req.key) begin
          run_key = shadow_key[shadow_rd];
          run_pos = consume_run();
          batch.push_back('{run_key, run_pos, 1'b0});
        end
        if (shadow_rd < shadow_fill && shadow_key[shadow_rd] == req.key)
          void'(consume_run());
        batch.push_back('{req.key, req.pos, 1'b0});
        shadow_last_file = req.key;
        shadow_file_seen = 1'b1;
      end
      smd_pkg::CMD_FLUSH: begin
        // Flush what is left, skipping a run equal to the last file key.
        while (shadow_rd < shadow_fill) begin
          run_key = shadow_key[shadow_rd];
          run_pos = consume_run();
          if (!(shadow_file_seen && run_key == shadow_last_file))
            batch.push_back('{run_key, run_pos, 1'b0});
        end
        shadow_fill = 0;
        shadow_rd = 0;
        shadow_last_file = '0;
        shadow_file_seen = 1'b0;
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) merged_q.push_back(batch[i]);
  endfunction

  task automatic queue_req(logic [1:0] cmd, logic [smd_pkg::KEY_W-1:0] key,
                           logic [smd_pkg::POS_W-1:0] pos);
    req_q.push_back('{cmd, key, pos});
  endtask

  // Keys from a narrow low band, a narrow band under the top, or anywhere;
  // the narrow bands give plenty of equal keys.
  function automatic logic [smd_pkg::KEY_W-1:0] pick_key(int band);
    case (band)
      0: return smd_pkg::KEY_W'($urandom_range(0, 40));
      1: return KEY_MAX - smd_pkg::KEY_W'($urandom_range(0, 40));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [smd_pkg::POS_W-1:0] pick_pos();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return POS_MAX;
      2: return smd_pkg::POS_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One well-formed round: a sorted batch of loads with duplicate runs, a
  // sorted stream of file records, about half of them copying stored keys, and
  // optionally the closing flush.
  task automatic queue_merge_batch(int n_store, int n_file, bit do_flush);
    logic [smd_pkg::KEY_W-1:0] store_keys[$];
    logic [smd_pkg::KEY_W-1:0] file_keys[$];
    int band;
    band = $urandom_range(0, 3);
    for (int i = 0; i < n_store; i++) begin
      if (i > 0 && $urandom_range(0, 2) == 0)
        store_keys.push_back(store_keys[$urandom_range(0, i - 1)]);
      else
        store_keys.push_back(pick_key(band));
    end
    store_keys.sort();
    foreach (store_keys[i]) begin
      queue_req(smd_pkg::CMD_LOAD, store_keys[i], pick_pos());
      if (i < smd_pkg::ARRAY_DEPTH) counted_items++;
    end
    for (int i = 0; i < n_file; i++) begin
      if (n_store > 0 && $urandom_range(0, 1) == 0)
        file_keys.push_back(store_keys[$urandom_range(0, n_store - 1)]);
      else
        file_keys.push_back(pick_key(band));
    end
    file_keys.sort();
    foreach (file_keys[i]) queue_req(smd_pkg::CMD_FILE, file_keys[i], pick_pos());
    counted_items += n_file;
    if (do_flush) begin
      queue_req(smd_pkg::CMD_FLUSH, pick_key(2), pick_pos());
      counted_items++;
    end
  endtask

  // Noise: any command, any key, in no particular order.
  task automatic queue_noise(int n);
    logic [1:0] cmd;
    for (int i = 0; i < n; i++) begin
      cmd = 2'($urandom_range(0, 3));
      queue_req(cmd, pick_key($urandom_range(0, 2)), pick_pos());
      if (cmd == smd_pkg::CMD_FILE || cmd == smd_pkg::CMD_FLUSH) counted_items++;
    end
  endtask

  // Input driver: present the next pending item once the idle gap has run
  // out; keep valid and the payload steady until the transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_merge('{command, rec_key, rec_position});
        send_wait = draw_gap(send_left, send_quiet);
      end
      if (!in_valid || in_ready) begin
        if (send_wait == 0 && req_q.size() != 0) begin
          next_req = req_q.pop_front();
          in_valid <= 1'b1;
          command <= next_req.cmd;
          rec_key <= next_req.key;
          rec_position <= next_req.pos;
        end else begin
          in_valid <= 1'b0;
          if (send_wait > 0) send_wait--;
        end
      end
    end
  end

  // Output monitor: check each result transfer against the oldest owed
  // record, then hold ready low for a freshly drawn stall.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        seen = '{out_key, out_position, last_of_run};
        if (merged_q.size() == 0) begin
          $display("%0t: result with none expected: key %h position %h last %b",
                   $time, seen.key, seen.pos, seen.last);
          mismatches++;
        end else begin
          want = merged_q.pop_front();
          if (seen !== want) begin
            $display({"%0t: expected key %h position %h last %b, ",
                      "actual key %h position %h last %b"},
                     $time, want.key, want.pos, want.last,
                     seen.key, seen.pos, seen.last);
            mismatches++;
          end
        end
        recv_wait = draw_gap(recv_left, recv_quiet);
      end
      if (recv_wait > 0) begin
        out_ready <= 1'b0;
        recv_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Directed opening.
    // flush of an empty store: nothing out
    queue_req(smd_pkg::CMD_FLUSH, '0, '0);
    // spare code: no effect
    queue_req(CMD_SPARE, KEY_MAX, POS_MAX);
    // file record against an empty store
    queue_req(smd_pkg::CMD_FILE, smd_pkg::KEY_W'(42), smd_pkg::POS_W'(1));
    queue_req(smd_pkg::CMD_LOAD, '0, POS_MAX);
    queue_req(smd_pkg::CMD_LOAD, '0, smd_pkg::POS_W'(5));
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(7), '0);
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(7), smd_pkg::POS_W'(3));
    queue_req(smd_pkg::CMD_LOAD, KEY_MAX, POS_MAX - 1);
    // key-0 run by smallest position; 7 dropped
    queue_req(smd_pkg::CMD_FILE, smd_pkg::KEY_W'(7), smd_pkg::POS_W'(100));
    // load after merging began: goes behind
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(3), smd_pkg::POS_W'(9));
    // top run gives way to the file record
    queue_req(smd_pkg::CMD_FILE, KEY_MAX, POS_MAX);
    // out-of-order key 3 comes out here
    queue_req(smd_pkg::CMD_FLUSH, '0, '0);
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(30), smd_pkg::POS_W'(4));
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(10), smd_pkg::POS_W'(2));
    // unsorted store: 30 blocks the walk
    queue_req(smd_pkg::CMD_FILE, smd_pkg::KEY_W'(10), smd_pkg::POS_W'(8));
    // 30 flushed, run equal to last file key skipped
    queue_req(smd_pkg::CMD_FLUSH, '0, '0);
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(5), smd_pkg::POS_W'(6));
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(5), smd_pkg::POS_W'(2));
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(5), smd_pkg::POS_W'(2));
    queue_req(smd_pkg::CMD_LOAD, smd_pkg::KEY_W'(5), smd_pkg::POS_W'(6));
    // no file record: nothing skipped, tie on min
    queue_req(smd_pkg::CMD_FLUSH, smd_pkg::KEY_W'(5), '0);

    // Random part; open with an overfilled batch so the full store is hit.
    queue_merge_batch(smd_pkg::ARRAY_DEPTH + 3, 6, 1'b1);
    while (counted_items < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0: queue_noise($urandom_range(1, 6));
        1: queue_merge_batch($urandom_range(smd_pkg::ARRAY_DEPTH - 2,
                                            smd_pkg::ARRAY_DEPTH + 4),
                             $urandom_range(1, 12), 1'b1);
        // No flush: the next batch's loads land behind a part-merged store.
        2: queue_merge_batch($urandom_range(0, 8), $urandom_range(0, 6), 1'b0);
        default: queue_merge_batch($urandom_range(1, 12), $urandom_range(1, 8), 1'b1);
      endcase
    end
    queue_req(smd_pkg::CMD_FLUSH, '0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for the last input transfer, then for every owed record, then
    // allow the block time to show anything extra.
    while (req_q.size() != 0 || in_valid) @(posedge clk);
    while (merged_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (merged_q.size() != 0)
      $display("%0t: %0d expected records never arrived", $time, merged_q.size());
    if (mismatches == 0 && merged_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
